// File: rtl/sit_pkg.sv
// Shared constants for the segment intersection tester.
package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int TAG_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_ORIENT      = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;

endpackage

// File: rtl/sit_seg_if.sv
// Candidate segment channel: valid/ready plus one segment word.
interface sit_seg_if
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic        [TAG_W-1:0]       item_tag;
  logic                          last_item;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, item_tag, last_item,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, item_tag, last_item,
    output ready
  );
endinterface

// File: rtl/sit_res_if.sv
// Result channel: valid/ready plus one result word.
interface sit_res_if
  import sit_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             is_self;
  logic [TAG_W-1:0] result_tag;
  logic             result_last;

  modport source (
    output valid, hit, is_self, result_tag, result_last,
    input  ready
  );
  modport sink (
    input  valid, hit, is_self, result_tag, result_last,
    output ready
  );
endinterface

// File: rtl/sit_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
interface sit_cfg_if
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [COORD_WIDTH-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/sit_pipe.sv
// Four-stage orientation pipeline: differences, products, signs, decision.
module sit_pipe
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [COORD_WIDTH-1:0] ref_start_x,
  input  logic signed [COORD_WIDTH-1:0] ref_start_y,
  input  logic signed [COORD_WIDTH-1:0] ref_end_x,
  input  logic signed [COORD_WIDTH-1:0] ref_end_y,
  sit_seg_if.sink                       in_ch,
  sit_res_if.source                     out_ch
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic diff_t sub_ext(input logic [COORD_WIDTH-1:0] a,
                                    input logic [COORD_WIDTH-1:0] b);
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  // r inside the closed bounding box of a-b
  function automatic logic in_box(input logic signed [COORD_WIDTH-1:0] ax,
                                  input logic signed [COORD_WIDTH-1:0] ay,
                                  input logic signed [COORD_WIDTH-1:0] rx,
                                  input logic signed [COORD_WIDTH-1:0] ry,
                                  input logic signed [COORD_WIDTH-1:0] bx,
                                  input logic signed [COORD_WIDTH-1:0] by);
    logic in_x;
    logic in_y;
    in_x = ((ax <= rx) && (rx <= bx)) || ((bx <= rx) && (rx <= ax));
    in_y = ((ay <= ry) && (ry <= by)) || ((by <= ry) && (ry <= ay));
    return in_x && in_y;
  endfunction

  // stage valids and per-stage ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // stage 1: coordinate differences, box tests, self compare
  diff_t                  ma_nxt [NUM_ORIENT];
  diff_t                  mb_nxt [NUM_ORIENT];
  diff_t                  mc_nxt [NUM_ORIENT];
  diff_t                  md_nxt [NUM_ORIENT];
  logic [NUM_ORIENT-1:0]  box_nxt;
  logic                   self_nxt;

  diff_t                  ma_r [NUM_ORIENT];
  diff_t                  mb_r [NUM_ORIENT];
  diff_t                  mc_r [NUM_ORIENT];
  diff_t                  md_r [NUM_ORIENT];
  logic [NUM_ORIENT-1:0]  box1_r;
  logic                   self1_r;
  logic [TAG_W-1:0]       tag1_r;
  logic                   last1_r;

  always_comb begin
    // o1: ref, cand start
    ma_nxt[0] = sub_ext(ref_end_y, ref_start_y);
    mb_nxt[0] = sub_ext(in_ch.seg_start_x, ref_end_x);
    mc_nxt[0] = sub_ext(ref_end_x, ref_start_x);
    md_nxt[0] = sub_ext(in_ch.seg_start_y, ref_end_y);
    // o2: ref, cand end
    ma_nxt[1] = sub_ext(ref_end_y, ref_start_y);
    mb_nxt[1] = sub_ext(in_ch.seg_end_x, ref_end_x);
    mc_nxt[1] = sub_ext(ref_end_x, ref_start_x);
    md_nxt[1] = sub_ext(in_ch.seg_end_y, ref_end_y);
    // o3: cand, ref start
    ma_nxt[2] = sub_ext(in_ch.seg_end_y, in_ch.seg_start_y);
    mb_nxt[2] = sub_ext(ref_start_x, in_ch.seg_end_x);
    mc_nxt[2] = sub_ext(in_ch.seg_end_x, in_ch.seg_start_x);
    md_nxt[2] = sub_ext(ref_start_y, in_ch.seg_end_y);
    // o4: cand, ref end
    ma_nxt[3] = sub_ext(in_ch.seg_end_y, in_ch.seg_start_y);
    mb_nxt[3] = sub_ext(ref_end_x, in_ch.seg_end_x);
    mc_nxt[3] = sub_ext(in_ch.seg_end_x, in_ch.seg_start_x);
    md_nxt[3] = sub_ext(ref_end_y, in_ch.seg_end_y);

    box_nxt[0] = in_box(ref_start_x, ref_start_y, in_ch.seg_start_x, in_ch.seg_start_y,
                        ref_end_x, ref_end_y);
    box_nxt[1] = in_box(ref_start_x, ref_start_y, in_ch.seg_end_x, in_ch.seg_end_y,
                        ref_end_x, ref_end_y);
    box_nxt[2] = in_box(in_ch.seg_start_x, in_ch.seg_start_y, ref_start_x, ref_start_y,
                        in_ch.seg_end_x, in_ch.seg_end_y);
    box_nxt[3] = in_box(in_ch.seg_start_x, in_ch.seg_start_y, ref_end_x, ref_end_y,
                        in_ch.seg_end_x, in_ch.seg_end_y);

    self_nxt = (ref_start_x == in_ch.seg_start_x) && (ref_start_y == in_ch.seg_start_y) &&
               (ref_end_x == in_ch.seg_end_x) && (ref_end_y == in_ch.seg_end_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      for (int k = 0; k < NUM_ORIENT; k++) begin
        ma_r[k] <= ma_nxt[k];
        mb_r[k] <= mb_nxt[k];
        mc_r[k] <= mc_nxt[k];
        md_r[k] <= md_nxt[k];
      end
      box1_r  <= box_nxt;
      self1_r <= self_nxt;
      tag1_r  <= in_ch.item_tag;
      last1_r <= in_ch.last_item;
    end
  end

  // stage 2: cross product terms
  prod_t                 pa_r [NUM_ORIENT];
  prod_t                 pb_r [NUM_ORIENT];
  logic [NUM_ORIENT-1:0] box2_r;
  logic                  self2_r;
  logic [TAG_W-1:0]      tag2_r;
  logic                  last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int k = 0; k < NUM_ORIENT; k++) begin
        pa_r[k] <= ma_r[k] * mb_r[k];
        pb_r[k] <= mc_r[k] * md_r[k];
      end
      box2_r  <= box1_r;
      self2_r <= self1_r;
      tag2_r  <= tag1_r;
      last2_r <= last1_r;
    end
  end

  // stage 3: orientation signs
  logic [SW-1:0]         cross_val [NUM_ORIENT];
  logic [NUM_ORIENT-1:0] neg_nxt;
  logic [NUM_ORIENT-1:0] zero_nxt;

  logic [NUM_ORIENT-1:0] neg3_r;
  logic [NUM_ORIENT-1:0] zero3_r;
  logic [NUM_ORIENT-1:0] box3_r;
  logic                  self3_r;
  logic [TAG_W-1:0]      tag3_r;
  logic                  last3_r;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      cross_val[k] = {pa_r[k][PW-1], pa_r[k]} - {pb_r[k][PW-1], pb_r[k]};
      neg_nxt[k]   = cross_val[k][SW-1];
      zero_nxt[k]  = (cross_val[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      neg3_r  <= neg_nxt;
      zero3_r <= zero_nxt;
      box3_r  <= box2_r;
      self3_r <= self2_r;
      tag3_r  <= tag2_r;
      last3_r <= last2_r;
    end
  end

  // stage 4: decision into the output register
  logic diff12, diff34, general, collinear, hit_nxt;

  always_comb begin
    diff12    = (neg3_r[0] != neg3_r[1]) || (zero3_r[0] != zero3_r[1]);
    diff34    = (neg3_r[2] != neg3_r[3]) || (zero3_r[2] != zero3_r[3]);
    general   = diff12 && diff34;
    collinear = |(zero3_r & box3_r);
    hit_nxt   = !self3_r && (general || collinear);
  end

  logic             hit4_r;
  logic             self4_r;
  logic [TAG_W-1:0] tag4_r;
  logic             last4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      hit4_r  <= hit_nxt;
      self4_r <= self3_r;
      tag4_r  <= tag3_r;
      last4_r <= last3_r;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.hit         = hit4_r;
  assign out_ch.is_self     = self4_r;
  assign out_ch.result_tag  = tag4_r;
  assign out_ch.result_last = last4_r;

endmodule

// File: rtl/segment_intersect_tester.sv
// Throughput: one segment per cycle; four register stages (differences, products,
// orientation signs, output register), each stage holding its word under backpressure.
// Reset (rst_n low at a clock edge) clears the reference segment to all zero
// and empties the pipeline.
// Configuration writes are always accepted; unknown indexes are dropped.
module segment_intersect_tester
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sit_cfg_if.sink   cfg_ch,
  sit_seg_if.sink   in_ch,
  sit_res_if.source out_ch
);

  logic signed [COORD_WIDTH-1:0] ref_start_x_r;
  logic signed [COORD_WIDTH-1:0] ref_start_y_r;
  logic signed [COORD_WIDTH-1:0] ref_end_x_r;
  logic signed [COORD_WIDTH-1:0] ref_end_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_start_x_r <= '0;
      ref_start_y_r <= '0;
      ref_end_x_r   <= '0;
      ref_end_y_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_START_X: ref_start_x_r <= cfg_ch.data;
        REG_START_Y: ref_start_y_r <= cfg_ch.data;
        REG_END_X:   ref_end_x_r   <= cfg_ch.data;
        REG_END_Y:   ref_end_y_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  sit_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .ref_start_x (ref_start_x_r),
    .ref_start_y (ref_start_y_r),
    .ref_end_x   (ref_end_x_r),
    .ref_end_y   (ref_end_y_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule
